@@ design/tnpp_pkg.sv @@
// Package for the task name pattern parser.
// Holds the parser phase type, character codes, frequency limits and word layouts.
// No dependencies.
package tnpp_pkg;

	typedef enum logic [2:0] {
		PH_V    = 3'd0,
		PH_A    = 3'd1,
		PH_R    = 3'd2,
		PH_US   = 3'd3,
		PH_S    = 3'd4,
		PH_E    = 3'd5,
		PH_F    = 3'd6,
		PH_DONE = 3'd7
	} phase_t;

	localparam logic [7:0] CHAR_V    = 8'h76;
	localparam logic [7:0] CHAR_A    = 8'h61;
	localparam logic [7:0] CHAR_R    = 8'h72;
	localparam logic [7:0] CHAR_US   = 8'h5f;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] CHAR_9    = 8'h39;
	localparam logic [7:0] CHAR_NUL  = 8'h00;

	// Performance scale for a frequency of FREQ_MAX.
	localparam int unsigned PERF_ONE = 1024;

	localparam int unsigned FREQ_MIN  = 400;
	localparam int unsigned FREQ_MAX  = 2500;
	localparam int unsigned FREQ_STEP = 100;

	// Valid frequencies expressed in hundreds of MHz.
	localparam int unsigned HUND_MIN = FREQ_MIN / FREQ_STEP;
	localparam int unsigned HUND_MAX = FREQ_MAX / FREQ_STEP;

	localparam int unsigned PERF_W   = 11;
	localparam int unsigned PERF_SAT = (1 << PERF_W) - 1;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 40;

endpackage

@@ design/task_name_pattern_parser.sv @@
// Task name pattern parser top level: byte-wise parser of var_S_E[_FFFF] names.
// Depends on tnpp_pkg.
//
// The block takes one byte of a task name per clock on the s_ side and, on the
// word marked by s_tlast, delivers one result word on the m_ side, registered
// first in the input register and then in the output register. One byte is taken
// every cycle, except while a word marked by s_tlast waits in the input
// register for a full output register to drain; then the input stalls until
// m_tready rises. The throughput is set by a single register stage in front
// of the parser and the output register behind it, with no loop inside. The
// performance level is read from a small constant table indexed by the
// frequency in hundreds of MHz. A rejected name gives an all-zero result, and
// the parser returns to its reset state after every word marked by s_tlast.
module task_name_pattern_parser
	import tnpp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // char_byte[7:0]
	input  logic                  s_tlast,   // end_of_name
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// name_matched[0], cpu_first[7:1], cpu_last[14:8], has_frequency[15],
	// frequency_mhz[27:16], perf_level[38:28], zero[39]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Parser state
	phase_t     phase_q;
	logic [2:0] count_q;
	logic [6:0] start_q;
	logic [6:0] end_q;
	logic [6:0] hund_q;     // first two frequency digits
	logic       tail_nz_q;  // a non-zero digit in the last two frequency places
	logic       failed_q;

	phase_t     phase_n;
	logic [2:0] count_n;
	logic [6:0] start_n;
	logic [6:0] end_n;
	logic [6:0] hund_n;
	logic       tail_nz_n;
	logic       failed_n;

	logic       out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic       advance;
	logic       is_dig;
	logic [3:0] dig;
	logic       ok;
	logic       has_f;
	logic       hund_ok;
	logic [4:0] tab_idx;
	logic [PERF_W-1:0] perf_tab [HUND_MIN:HUND_MAX];
	logic [OUT_DATA_W-1:0] result;

	// Performance levels, rounded and saturated, worked out at elaboration.
	for (genvar gk = HUND_MIN; gk <= HUND_MAX; gk++) begin : g_perf
		localparam int unsigned RAW = (PERF_ONE * gk * 4 + 50) / 100;
		assign perf_tab[gk] = (RAW > PERF_SAT) ? PERF_W'(PERF_SAT) : PERF_W'(RAW);
	end

	// A closing word can only leave once the output register is free.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	assign is_dig = (char_s1 >= CHAR_0) && (char_s1 <= CHAR_9);
	assign dig    = is_dig ? 4'(char_s1 - CHAR_0) : 4'd0;

	always_comb begin
		phase_n   = phase_q;
		count_n   = count_q;
		start_n   = start_q;
		end_n     = end_q;
		hund_n    = hund_q;
		tail_nz_n = tail_nz_q;
		failed_n  = failed_q;
		if (!failed_q && phase_q != PH_DONE) begin
			unique case (phase_q)
				PH_V: begin
					if (char_s1 == CHAR_V) phase_n = PH_A; else failed_n = 1'b1;
				end
				PH_A: begin
					if (char_s1 == CHAR_A) phase_n = PH_R; else failed_n = 1'b1;
				end
				PH_R: begin
					if (char_s1 == CHAR_R) phase_n = PH_US; else failed_n = 1'b1;
				end
				PH_US: begin
					if (char_s1 == CHAR_US) begin
						phase_n = PH_S;
						count_n = 3'd0;
					end else begin
						failed_n = 1'b1;
					end
				end
				PH_S: begin
					if (is_dig && count_q < 3'd2) begin
						start_n = 7'(start_q * 7'd10 + 7'(dig));
						count_n = count_q + 3'd1;
					end else if (char_s1 == CHAR_US && count_q != 3'd0) begin
						phase_n = PH_E;
						count_n = 3'd0;
					end else begin
						failed_n = 1'b1;
					end
				end
				PH_E: begin
					if (is_dig && count_q < 3'd2) begin
						end_n   = 7'(end_q * 7'd10 + 7'(dig));
						count_n = count_q + 3'd1;
					end else if (char_s1 == CHAR_US && count_q != 3'd0) begin
						phase_n = PH_F;
						count_n = 3'd0;
					end else if (char_s1 == CHAR_NUL && count_q != 3'd0) begin
						phase_n = PH_DONE;
						count_n = 3'd0;
					end else begin
						failed_n = 1'b1;
					end
				end
				PH_F: begin
					if (is_dig && count_q < 3'd4) begin
						if (count_q < 3'd2) begin
							hund_n = 7'(hund_q * 7'd10 + 7'(dig));
						end else if (dig != 4'd0) begin
							tail_nz_n = 1'b1;
						end
						count_n = count_q + 3'd1;
					end else if (char_s1 == CHAR_NUL && count_q == 3'd4) begin
						phase_n = PH_DONE;
					end else begin
						failed_n = 1'b1;
					end
				end
				default: failed_n = 1'b1;
			endcase
		end
	end

	// The frequency is valid exactly when its hundreds lie in range and the
	// last two digits are zero.
	always_comb begin
		has_f   = (count_n == 3'd4);
		hund_ok = !tail_nz_n && (hund_n >= 7'(HUND_MIN)) && (hund_n <= 7'(HUND_MAX));
		ok      = !failed_n && (phase_n == PH_DONE) && (start_n <= end_n)
		          && (!has_f || hund_ok);
		tab_idx = hund_ok ? hund_n[4:0] : 5'(HUND_MIN);
		result  = '0;
		if (ok) begin
			result[0]    = 1'b1;
			result[7:1]  = start_n;
			result[14:8] = end_n;
			if (has_f) begin
				result[15]    = 1'b1;
				result[27:16] = 12'(hund_n) * 12'd100;
				result[38:28] = perf_tab[tab_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_V;
			count_q   <= 3'd0;
			start_q   <= 7'd0;
			end_q     <= 7'd0;
			hund_q    <= 7'd0;
			tail_nz_q <= 1'b0;
			failed_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q   <= PH_V;
				count_q   <= 3'd0;
				start_q   <= 7'd0;
				end_q     <= 7'd0;
				hund_q    <= 7'd0;
				tail_nz_q <= 1'b0;
				failed_q  <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				count_q   <= count_n;
				start_q   <= start_n;
				end_q     <= end_n;
				hund_q    <= hund_n;
				tail_nz_q <= tail_nz_n;
				failed_q  <= failed_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ design/tnpp_checker.sv @@
// Port-level checks for the task name pattern parser, bound to its top level.
// Depends on tnpp_pkg and task_name_pattern_parser.
module tnpp_checker
	import tnpp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A rejected name gives an all-zero word.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata == '0)
		else $error("rejected name with non-zero fields");

	// Without a frequency its fields stay zero.
	a_nofreq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[15] |-> m_tdata[OUT_DATA_W-1:16] == '0)
		else $error("frequency fields set without a frequency");

	a_cpu_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[7:1] <= m_tdata[14:8])
		else $error("start CPU above end CPU on a match");

	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[0]
			&& m_tdata[27:16] >= 12'(FREQ_MIN) && m_tdata[27:16] <= 12'(FREQ_MAX))
		else $error("frequency flagged but out of range");

endmodule

bind task_name_pattern_parser tnpp_checker u_tnpp_checker (.*);
